// File: hw/rtl/bbav_pkg.sv
// Shared types, constants and fixed-point helpers for the Bernstein basis evaluator.
package bbav_pkg;

    localparam int MAX_DEGREE = 15;
    localparam int FRAC_BITS  = 16;
    localparam int IDX_W      = 4;
    localparam int VAL_W      = FRAC_BITS + 1;
    localparam int PROD_W     = 2 * VAL_W;
    localparam int SUM_W      = VAL_W + 1;
    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;

    localparam logic [VAL_W-1:0]  FIX_ONE  = VAL_W'(1) << FRAC_BITS;
    localparam logic [VAL_W-1:0]  FIX_ZERO = '0;
    localparam logic [PROD_W-1:0] FIX_HALF = PROD_W'(1) << (FRAC_BITS - 1);

    localparam logic [IDX_W-1:0] DEGREE_MAX   = IDX_W'(MAX_DEGREE);
    localparam logic [IDX_W-1:0] DEGREE_RESET = IDX_W'(3);

    localparam logic [PADDR_W-1:0] ADDR_DEGREE = PADDR_W'(0);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_EMIT
    } t_state;

    function automatic logic [SUM_W-1:0] fx_round(input logic [PROD_W-1:0] prod);
        logic [PROD_W-1:0] biased;
        biased   = prod + FIX_HALF;
        fx_round = biased[FRAC_BITS +: SUM_W];
    endfunction

    function automatic logic [VAL_W-1:0] fx_sat(input logic [SUM_W-1:0] x);
        fx_sat = (x > SUM_W'(FIX_ONE)) ? FIX_ONE : x[VAL_W-1:0];
    endfunction

endpackage

// File: hw/rtl/bbav_step_unit.sv
// Shared multiply-add unit that splits one stored value into its (1-u) and u parts.
module bbav_step_unit
    import bbav_pkg::*;
(
    input  logic [VAL_W-1:0] i_held,
    input  logic [VAL_W-1:0] i_u,
    input  logic [VAL_W-1:0] i_u1,
    input  logic [VAL_W-1:0] i_carry,
    output logic [VAL_W-1:0] o_keep,
    output logic [VAL_W-1:0] o_carry
);

    logic [PROD_W-1:0] prod_lo;
    logic [PROD_W-1:0] prod_hi;
    logic [SUM_W-1:0]  part_lo;
    logic [SUM_W-1:0]  part_hi;
    logic [SUM_W-1:0]  sum_keep;

    assign prod_lo  = PROD_W'(i_held) * PROD_W'(i_u1);
    assign prod_hi  = PROD_W'(i_held) * PROD_W'(i_u);
    assign part_lo  = fx_round(prod_lo);
    assign part_hi  = fx_round(prod_hi);
    assign sum_keep = SUM_W'(i_carry) + SUM_W'(fx_sat(part_lo));
    assign o_keep   = fx_sat(sum_keep);
    assign o_carry  = fx_sat(part_hi);

endmodule

// File: hw/rtl/bernstein_basis_all_values.sv
// Top level of the Bernstein basis evaluator with its sequencer, row store and APB register.
//
// Usage: each input transaction carries a parameter u (17 bits, 65536 = 1.0); values
// above 1.0 are taken as 1.0. The block answers with degree+1 output transactions,
// index k = 0..degree, value B(k,degree,u), and the last one flagged by o_last_value.
// The degree register lies at APB byte address 0 and resets to 3. The user must write it
// only while the block is idle; the block itself does not enforce this.
// Timing: o_stall is high from the accepting edge until the last value has been moved
// into the output register. The single shared multiply-add unit performs one step of the
// triangular recurrence per cycle, and the values then leave one per cycle through the
// output register while i_stall is low.
// The output register holds a transaction while i_stall is high; emission then pauses
// and the remaining values wait in the row store. A new input transaction can be taken
// while the last value of the previous item still waits in the output register.
// Reset clears the sequencer, the output valid and the degree register to 3.
module bernstein_basis_all_values
    import bbav_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [VAL_W-1:0]   i_param_u,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [IDX_W-1:0]   o_basis_index,
    output logic [VAL_W-1:0]   o_basis_value,
    output logic               o_last_value,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    t_state r_state, n_state;

    logic [IDX_W-1:0] r_degree;
    logic [IDX_W-1:0] r_n, n_n;
    logic [IDX_W-1:0] r_j, n_j;
    logic [IDX_W-1:0] r_k, n_k;
    logic [VAL_W-1:0] r_carry, n_carry;
    logic [VAL_W-1:0] r_u, n_u;
    logic [VAL_W-1:0] r_u1, n_u1;
    logic [VAL_W-1:0] r_work [MAX_DEGREE+1];

    logic             r_out_valid, n_out_valid;
    logic [IDX_W-1:0] r_out_index, n_out_index;
    logic [VAL_W-1:0] r_out_value, n_out_value;
    logic             r_out_last, n_out_last;

    logic             in_accept;
    logic             cfg_write;
    logic             out_load;
    logic             last_step;
    logic [IDX_W-1:0] deg_clamped;
    logic [VAL_W-1:0] u_clamped;
    logic [VAL_W-1:0] held;
    logic [VAL_W-1:0] carry_in;
    logic [VAL_W-1:0] step_keep;
    logic [VAL_W-1:0] step_carry;

    assign in_accept   = i_valid && (r_state == ST_IDLE);
    assign cfg_write   = psel && penable && pwrite && pready;
    assign out_load    = (r_state == ST_EMIT) && (!r_out_valid || !i_stall);
    assign last_step   = (r_k == r_j - IDX_W'(1));
    assign deg_clamped = (r_degree > DEGREE_MAX) ? DEGREE_MAX : r_degree;
    assign u_clamped   = (i_param_u > FIX_ONE) ? FIX_ONE : i_param_u;
    assign held        = r_work[r_k];
    assign carry_in    = (r_k == '0) ? FIX_ZERO : r_carry;

    bbav_step_unit u_step (
        .i_held  (held),
        .i_u     (r_u),
        .i_u1    (r_u1),
        .i_carry (carry_in),
        .o_keep  (step_keep),
        .o_carry (step_carry)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    n_state = (deg_clamped == '0) ? ST_EMIT : ST_CALC;
                end
            end
            ST_CALC: begin
                if (last_step && (r_j == r_n)) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_load && (r_k == r_n)) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_n         = r_n;
        n_j         = r_j;
        n_k         = r_k;
        n_carry     = r_carry;
        n_u         = r_u;
        n_u1        = r_u1;
        n_out_valid = r_out_valid && i_stall;
        n_out_index = r_out_index;
        n_out_value = r_out_value;
        n_out_last  = r_out_last;
        unique case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    n_n  = deg_clamped;
                    n_u  = u_clamped;
                    n_u1 = FIX_ONE - u_clamped;
                    n_j  = IDX_W'(1);
                    n_k  = '0;
                end
            end
            ST_CALC: begin
                n_carry = step_carry;
                if (last_step) begin
                    n_k = '0;
                    n_j = r_j + IDX_W'(1);
                end else begin
                    n_k = r_k + IDX_W'(1);
                end
            end
            ST_EMIT: begin
                if (out_load) begin
                    n_out_valid = 1'b1;
                    n_out_index = r_k;
                    n_out_value = held;
                    n_out_last  = (r_k == r_n);
                    n_k         = r_k + IDX_W'(1);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_degree    <= DEGREE_RESET;
            r_n         <= '0;
            r_j         <= '0;
            r_k         <= '0;
            r_carry     <= FIX_ZERO;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_n         <= n_n;
            r_j         <= n_j;
            r_k         <= n_k;
            r_carry     <= n_carry;
            r_out_valid <= n_out_valid;
            if (cfg_write && (paddr == ADDR_DEGREE)) begin
                r_degree <= pwdata[IDX_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_u         <= n_u;
        r_u1        <= n_u1;
        r_out_index <= n_out_index;
        r_out_value <= n_out_value;
        r_out_last  <= n_out_last;
        if (in_accept) begin
            r_work[0] <= FIX_ONE;
        end else if (r_state == ST_CALC) begin
            r_work[r_k] <= step_keep;
            if (last_step) begin
                r_work[r_j] <= step_carry;
            end
        end
    end

    assign o_stall       = (r_state != ST_IDLE);
    assign o_valid       = r_out_valid;
    assign o_basis_index = r_out_index;
    assign o_basis_value = r_out_value;
    assign o_last_value  = r_out_last;
    assign pready        = 1'b1;
    assign prdata        = (paddr == ADDR_DEGREE) ? PDATA_W'(r_degree) : '0;

    a_calc_inner_below_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CALC) |-> (r_k < r_j))
        else $error("Inner position reached the pass number during a pass.");

    a_calc_pass_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CALC) |-> ((r_j != '0) && (r_j <= r_n)))
        else $error("Pass number left the range one to degree.");

    a_first_value_is_one_at_degree_zero: assert property (@(posedge i_clk)
        disable iff (!i_rst_n)
        (in_accept && (deg_clamped == '0)) |=> ((r_state == ST_EMIT) && (r_work[0] == FIX_ONE)))
        else $error("Degree zero did not go straight to emission of 1.0.");

    a_last_ends_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && (r_k == r_n)) |=> (r_out_valid && r_out_last && (r_state == ST_IDLE)))
        else $error("Last value was not flagged or the item did not end.");

endmodule
